// File: sv/i2cmrc_pkg.sv
// Shared types and constants of the I2C master register controller.
package i2cmrc_pkg;

  localparam logic [2:0] REQ_MAIN_RD = 3'd0;
  localparam logic [2:0] REQ_MAIN_WR = 3'd1;
  localparam logic [2:0] REQ_AUX_RD  = 3'd2;
  localparam logic [2:0] REQ_AUX_WR  = 3'd3;
  localparam logic [2:0] REQ_RESP    = 3'd4;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_SEND  = 3'd2;
  localparam logic [2:0] CMD_RECV  = 3'd3;
  localparam logic [2:0] CMD_STOP  = 3'd4;

  localparam logic [9:0] OFF_ADDR     = 10'h000;
  localparam logic [9:0] OFF_COUNT    = 10'h024;
  localparam logic [9:0] OFF_CTRL     = 10'h028;
  localparam logic [9:0] OFF_EN       = 10'h02c;
  localparam logic [9:0] OFF_CTRL_HI  = 10'h050;
  localparam logic [9:0] OFF_CLK      = 10'h054;
  localparam logic [9:0] OFF_AUX_CTRL = 10'h26c;

  localparam logic [7:0] TX_WORD_BASE = 8'd1;
  localparam logic [7:0] RX_WORD_BASE = 8'd12;

  localparam logic [7:0] CTRL_MASK    = 8'hf3;
  localparam logic [7:0] CTRL_HI_MASK = 8'hc3;
  localparam logic [6:0] EN_WR_MASK   = 7'h71;
  localparam logic [6:0] EN_COND      = 7'h70;
  localparam logic [6:0] EN_INT       = 7'h02;
  localparam logic [6:0] EN_NOACK     = 7'h04;
  localparam int unsigned EN_XFER_BIT    = 0;
  localparam int unsigned EN_NOSTOP_BIT  = 4;
  localparam int unsigned EN_NOSTART_BIT = 5;
  localparam int unsigned CH_IGNORE_ACK_BIT = 1;
  localparam int unsigned AUX_RELEASE_BIT   = 1;

  localparam logic [1:0] DIR_TX = 2'd0;
  localparam logic [1:0] DIR_RX = 2'd1;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_SEND  = 4'b0100,
    PH_RECV  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [9:0]  offset;
    logic [31:0] wdata;
    logic        target_ack;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
    logic        busy_reject;
    logic [2:0]  bus_cmd;
    logic [6:0]  bus_addr;
    logic        bus_read;
    logic [7:0]  bus_byte;
    logic        transfer_done;
  } res_t;

endpackage

// File: sv/i2cmrc_engine.sv
// Register file and transfer sequencer: computes one result per item and updates state.
module i2cmrc_engine #(
  parameter int DATA_WORDS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  i2cmrc_pkg::item_t   item_i,
  output i2cmrc_pkg::res_t    res_o
);

  localparam int IdxW   = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int MaxLen = 4 * DATA_WORDS;

  logic [7:0]  tgt_q, tgt_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [7:0]  ctl_q, ctl_d;
  logic [6:0]  en_q, en_d;
  logic [7:0]  ch_q, ch_d;
  logic [31:0] clk_q, clk_d;
  logic        rel_q, rel_d;
  logic        open_q, open_d;
  logic [5:0]  bi_q, bi_d;
  i2cmrc_pkg::phase_e phase_q, phase_d;

  logic [31:0] tx_q [DATA_WORDS];
  logic [31:0] rx_q [DATA_WORDS];

  logic            tx_we, rx_we;
  logic [IdxW-1:0] rx_widx;
  logic [1:0]      rx_lane;
  logic [IdxW-1:0] tx_ridx;
  logic [31:0]     tx_rdata;

  logic [7:0]  owd, tx_rel, rx_rel;
  logic        aligned, in_tx, in_rx;
  logic [5:0]  bi_inc, nb_idx;
  logic        do_next, do_fin, fin_nack, is_wr;

  assign owd     = item_i.offset[9:2];
  assign aligned = (item_i.offset[1:0] == 2'd0);
  assign tx_rel  = owd - i2cmrc_pkg::TX_WORD_BASE;
  assign rx_rel  = owd - i2cmrc_pkg::RX_WORD_BASE;
  assign in_tx   = aligned && (owd >= i2cmrc_pkg::TX_WORD_BASE) && (tx_rel < 8'(DATA_WORDS));
  assign in_rx   = aligned && (owd >= i2cmrc_pkg::RX_WORD_BASE) && (rx_rel < 8'(DATA_WORDS));

  assign bi_inc  = bi_q + 6'd1;
  assign nb_idx  = (item_i.req_type == i2cmrc_pkg::REQ_MAIN_WR) ? 6'd0 :
                   (phase_q == i2cmrc_pkg::PH_START) ? bi_q : bi_inc;

  assign tx_ridx  = (item_i.req_type == i2cmrc_pkg::REQ_MAIN_RD) ? tx_rel[IdxW-1:0]
                                                                  : nb_idx[IdxW+1:2];
  assign tx_rdata = tx_q[tx_ridx];
  assign is_wr    = (item_i.req_type == i2cmrc_pkg::REQ_MAIN_WR) ||
                    (item_i.req_type == i2cmrc_pkg::REQ_AUX_WR);

  always_comb begin
    res_o    = '0;
    tgt_d    = tgt_q;
    cnt_d    = cnt_q;
    ctl_d    = ctl_q;
    en_d     = en_q;
    ch_d     = ch_q;
    clk_d    = clk_q;
    rel_d    = rel_q;
    open_d   = open_q;
    bi_d     = bi_q;
    phase_d  = phase_q;
    tx_we    = 1'b0;
    rx_we    = 1'b0;
    rx_widx  = bi_q[IdxW+1:2];
    rx_lane  = bi_q[1:0];
    do_next  = 1'b0;
    do_fin   = 1'b0;
    fin_nack = 1'b0;

    if (is_wr && (phase_q != i2cmrc_pkg::PH_IDLE)) begin
      res_o.busy_reject = 1'b1;
    end else begin
      unique case (item_i.req_type)
        i2cmrc_pkg::REQ_MAIN_RD: begin
          priority if (in_tx) begin
            res_o.read_data = tx_rdata;
          end else if (in_rx) begin
            res_o.read_data = rx_q[rx_rel[IdxW-1:0]];
          end else if (item_i.offset == i2cmrc_pkg::OFF_ADDR) begin
            res_o.read_data = 32'(tgt_q);
          end else if (item_i.offset == i2cmrc_pkg::OFF_COUNT) begin
            res_o.read_data = 32'(cnt_q);
          end else if (item_i.offset == i2cmrc_pkg::OFF_CTRL) begin
            res_o.read_data = 32'(ctl_q);
          end else if (item_i.offset == i2cmrc_pkg::OFF_EN) begin
            res_o.read_data = 32'(en_q);
          end else if (item_i.offset == i2cmrc_pkg::OFF_CTRL_HI) begin
            res_o.read_data = 32'(ch_q);
          end else if (item_i.offset == i2cmrc_pkg::OFF_CLK) begin
            res_o.read_data = clk_q;
          end else begin
            res_o.access_error = 1'b1;
          end
        end
        i2cmrc_pkg::REQ_MAIN_WR: begin
          priority if (in_tx) begin
            tx_we = 1'b1;
          end else if (in_rx) begin
            tx_we = 1'b0;
          end else if (item_i.offset == i2cmrc_pkg::OFF_ADDR) begin
            tgt_d = item_i.wdata[7:0];
          end else if (item_i.offset == i2cmrc_pkg::OFF_COUNT) begin
            cnt_d = item_i.wdata[5:0];
          end else if (item_i.offset == i2cmrc_pkg::OFF_CTRL) begin
            ctl_d = item_i.wdata[7:0] & i2cmrc_pkg::CTRL_MASK;
          end else if (item_i.offset == i2cmrc_pkg::OFF_EN) begin
            en_d = item_i.wdata[6:0] & i2cmrc_pkg::EN_WR_MASK;
            if (en_d[i2cmrc_pkg::EN_XFER_BIT]) begin
              if (!rel_q || (cnt_q > 6'(MaxLen)) || (ctl_q[1:0] > i2cmrc_pkg::DIR_RX)) begin
                do_fin   = 1'b1;
                fin_nack = 1'b1;
              end else begin
                bi_d = 6'd0;
                if (en_d[i2cmrc_pkg::EN_NOSTART_BIT]) begin
                  if (!open_q) begin
                    do_fin   = 1'b1;
                    fin_nack = 1'b1;
                  end else begin
                    do_next = 1'b1;
                  end
                end else begin
                  res_o.bus_cmd  = i2cmrc_pkg::CMD_START;
                  res_o.bus_addr = tgt_q[7:1];
                  res_o.bus_read = ctl_q[0];
                  open_d         = 1'b1;
                  phase_d        = i2cmrc_pkg::PH_START;
                end
              end
            end
          end else if (item_i.offset == i2cmrc_pkg::OFF_CTRL_HI) begin
            ch_d = item_i.wdata[7:0] & i2cmrc_pkg::CTRL_HI_MASK;
          end else if (item_i.offset == i2cmrc_pkg::OFF_CLK) begin
            clk_d = item_i.wdata;
          end else begin
            res_o.access_error = 1'b1;
          end
        end
        i2cmrc_pkg::REQ_AUX_RD: begin
          res_o.access_error = (item_i.offset != i2cmrc_pkg::OFF_AUX_CTRL);
        end
        i2cmrc_pkg::REQ_AUX_WR: begin
          if (item_i.offset == i2cmrc_pkg::OFF_AUX_CTRL) begin
            if (item_i.wdata[i2cmrc_pkg::AUX_RELEASE_BIT]) begin
              rel_d = 1'b1;
            end
          end else begin
            res_o.access_error = 1'b1;
          end
        end
        i2cmrc_pkg::REQ_RESP: begin
          unique case (phase_q)
            i2cmrc_pkg::PH_START: begin
              if (!item_i.target_ack) begin
                open_d   = 1'b0;
                do_fin   = 1'b1;
                fin_nack = 1'b1;
              end else begin
                do_next = 1'b1;
              end
            end
            i2cmrc_pkg::PH_SEND: begin
              if (!item_i.target_ack) begin
                do_fin   = 1'b1;
                fin_nack = 1'b1;
              end else begin
                bi_d    = bi_inc;
                do_next = 1'b1;
              end
            end
            i2cmrc_pkg::PH_RECV: begin
              rx_we   = (4'(bi_q[5:2]) < 4'(DATA_WORDS));
              bi_d    = bi_inc;
              do_next = 1'b1;
            end
            default: begin
              do_next = 1'b0;
            end
          endcase
        end
        default: begin
          do_next = 1'b0;
        end
      endcase
    end

    if (do_next) begin
      if ((nb_idx >= cnt_q) || (4'(nb_idx[5:2]) >= 4'(DATA_WORDS))) begin
        do_fin = 1'b1;
      end else if (ctl_q[1:0] == i2cmrc_pkg::DIR_RX) begin
        res_o.bus_cmd = i2cmrc_pkg::CMD_RECV;
        phase_d       = i2cmrc_pkg::PH_RECV;
      end else begin
        res_o.bus_cmd  = i2cmrc_pkg::CMD_SEND;
        res_o.bus_byte = tx_rdata[8*nb_idx[1:0] +: 8];
        phase_d        = i2cmrc_pkg::PH_SEND;
      end
    end

    if (do_fin) begin
      if (!en_d[i2cmrc_pkg::EN_NOSTOP_BIT] && open_d) begin
        res_o.bus_cmd = i2cmrc_pkg::CMD_STOP;
        open_d        = 1'b0;
      end
      en_d = (en_d & i2cmrc_pkg::EN_COND) | i2cmrc_pkg::EN_INT;
      if (fin_nack && !ch_q[i2cmrc_pkg::CH_IGNORE_ACK_BIT]) begin
        en_d = en_d | i2cmrc_pkg::EN_NOACK;
      end
      phase_d             = i2cmrc_pkg::PH_IDLE;
      res_o.transfer_done = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q   <= '0;
      cnt_q   <= '0;
      ctl_q   <= '0;
      en_q    <= '0;
      ch_q    <= '0;
      clk_q   <= '0;
      rel_q   <= 1'b0;
      open_q  <= 1'b0;
      bi_q    <= '0;
      phase_q <= i2cmrc_pkg::PH_IDLE;
      for (int i = 0; i < DATA_WORDS; i++) begin
        tx_q[i] <= '0;
        rx_q[i] <= '0;
      end
    end else if (fire_i) begin
      tgt_q   <= tgt_d;
      cnt_q   <= cnt_d;
      ctl_q   <= ctl_d;
      en_q    <= en_d;
      ch_q    <= ch_d;
      clk_q   <= clk_d;
      rel_q   <= rel_d;
      open_q  <= open_d;
      bi_q    <= bi_d;
      phase_q <= phase_d;
      if (tx_we) begin
        tx_q[tx_rel[IdxW-1:0]] <= item_i.wdata;
      end
      if (rx_we) begin
        rx_q[rx_widx][8*rx_lane +: 8] <= item_i.rx_byte;
      end
    end
  end

endmodule

// File: sv/i2c_master_register_controller_core.sv
// Top level of the I2C master register controller: input stage, engine, result stage.
//
// Input channel (in_valid_i/in_ready_o) carries one request per transfer:
// a register read or write in the main or auxiliary window, or a response
// from the bus target (ack, received byte). Output channel
// (out_valid_o/out_ready_i) returns exactly one result per request: read
// data, error flags, the next bus command and the transfer-done flag.
// The request lands in the input register, is decoded and applied to the
// register file and sequencer, and the result is held in the output
// register. Throughput is one request per cycle while results are taken,
// as the register file and the sequencer state update with each result.
// Reset clears all registers, data words and the sequencer; both stages
// come up empty. When the receiver stalls, the result is held, the input
// register fills behind it and in_ready_o drops until the result is taken.
module i2c_master_register_controller_core #(
  parameter int DATA_WORDS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [9:0]  offset_i,
  input  logic [31:0] wdata_i,
  input  logic        target_ack_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic        access_error_o,
  output logic        busy_reject_o,
  output logic [2:0]  bus_cmd_o,
  output logic [6:0]  bus_addr_o,
  output logic        bus_read_o,
  output logic [7:0]  bus_byte_o,
  output logic        transfer_done_o
);

  logic              in_valid_q;
  logic              out_valid_q;
  logic              advance;
  i2cmrc_pkg::item_t item_q;
  i2cmrc_pkg::res_t  res, res_q;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{req_type:   req_type_i,
                  offset:     offset_i,
                  wdata:      wdata_i,
                  target_ack: target_ack_i,
                  rx_byte:    rx_byte_i};
    end
  end

  i2cmrc_engine #(
    .DATA_WORDS(DATA_WORDS)
  ) u_engine (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(advance),
    .item_i(item_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = res_q.read_data;
  assign access_error_o  = res_q.access_error;
  assign busy_reject_o   = res_q.busy_reject;
  assign bus_cmd_o       = res_q.bus_cmd;
  assign bus_addr_o      = res_q.bus_addr;
  assign bus_read_o      = res_q.bus_read;
  assign bus_byte_o      = res_q.bus_byte;
  assign transfer_done_o = res_q.transfer_done;

endmodule

// File: sv/i2cmrc_checker.sv
// Port-level checker for the I2C master register controller, bound to the top level.
module i2cmrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] read_data_o,
  input logic        access_error_o,
  input logic        busy_reject_o,
  input logic [2:0]  bus_cmd_o,
  input logic [6:0]  bus_addr_o,
  input logic        bus_read_o,
  input logic        transfer_done_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o) && $stable(bus_cmd_o))
    else $error("result changed while stalled");

  a_done_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && transfer_done_o |->
      bus_cmd_o == i2cmrc_pkg::CMD_STOP || bus_cmd_o == i2cmrc_pkg::CMD_NONE)
    else $error("transfer completion with a data or start command");

  a_busy_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && busy_reject_o |->
      !access_error_o && read_data_o == 32'd0 && bus_cmd_o == i2cmrc_pkg::CMD_NONE &&
      !transfer_done_o)
    else $error("rejected write carried other result fields");

  a_addr_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bus_cmd_o != i2cmrc_pkg::CMD_START |-> bus_addr_o == 7'd0 && !bus_read_o)
    else $error("target address outside a start command");

endmodule

bind i2c_master_register_controller_core i2cmrc_checker u_i2cmrc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .read_data_o    (read_data_o),
  .access_error_o (access_error_o),
  .busy_reject_o  (busy_reject_o),
  .bus_cmd_o      (bus_cmd_o),
  .bus_addr_o     (bus_addr_o),
  .bus_read_o     (bus_read_o),
  .transfer_done_o(transfer_done_o)
);

// File: test/i2c_master_register_controller_core_test.sv
// Testbench for the I2C master register controller core: directed and random transfers.
module i2c_master_register_controller_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_WORDS = 8;
  localparam int RANDOM_PER_PHASE = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  req_type_i = '0;
  logic [9:0]  offset_i = '0;
  logic [31:0] wdata_i = '0;
  logic        target_ack_i = 1'b0;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] read_data_o;
  logic        access_error_o;
  logic        busy_reject_o;
  logic [2:0]  bus_cmd_o;
  logic [6:0]  bus_addr_o;
  logic        bus_read_o;
  logic [7:0]  bus_byte_o;
  logic        transfer_done_o;

  i2c_master_register_controller_core #(
    .DATA_WORDS(DATA_WORDS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .offset_i       (offset_i),
    .wdata_i        (wdata_i),
    .target_ack_i   (target_ack_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o),
    .access_error_o (access_error_o),
    .busy_reject_o  (busy_reject_o),
    .bus_cmd_o      (bus_cmd_o),
    .bus_addr_o     (bus_addr_o),
    .bus_read_o     (bus_read_o),
    .bus_byte_o     (bus_byte_o),
    .transfer_done_o(transfer_done_o)
  );

  always #5 clk_i = ~clk_i;

  int unsigned       idle_pct = 0;
  int unsigned       stall_pct = 0;
  int unsigned       errors = 0;
  i2cmrc_pkg::res_t  pending_responses[$];
  i2cmrc_pkg::res_t  due;

  // Controller state as seen through the registers
  logic [7:0]  addr_q = '0;
  logic [31:0] tx_q[DATA_WORDS] = '{default: '0};
  logic [31:0] rx_q[DATA_WORDS] = '{default: '0};
  logic [5:0]  count_q = '0;
  logic [7:0]  ctrl_q = '0;
  logic [6:0]  en_q = '0;
  logic [7:0]  ctrl_hi_q = '0;
  logic [31:0] clkdiv_q = '0;
  bit          released_q = 1'b0;
  bit          bus_open_q = 1'b0;
  i2cmrc_pkg::phase_e phase_q = i2cmrc_pkg::PH_IDLE;
  logic [5:0]  byte_idx_q = '0;

  function automatic logic [9:0] tx_off(int unsigned i);
    return 10'((i2cmrc_pkg::TX_WORD_BASE + i) * 4);
  endfunction

  function automatic logic [9:0] rx_off(int unsigned i);
    return 10'((i2cmrc_pkg::RX_WORD_BASE + i) * 4);
  endfunction

  function automatic void complete_xfer(input bit no_ack, inout i2cmrc_pkg::res_t r);
    if (!en_q[i2cmrc_pkg::EN_NOSTOP_BIT] && bus_open_q) begin
      r.bus_cmd = i2cmrc_pkg::CMD_STOP;
      bus_open_q = 1'b0;
    end
    en_q = (en_q & i2cmrc_pkg::EN_COND) | i2cmrc_pkg::EN_INT;
    if (no_ack && !ctrl_hi_q[i2cmrc_pkg::CH_IGNORE_ACK_BIT]) begin
      en_q = en_q | i2cmrc_pkg::EN_NOACK;
    end
    phase_q = i2cmrc_pkg::PH_IDLE;
    r.transfer_done = 1'b1;
  endfunction

  function automatic void issue_next_byte(inout i2cmrc_pkg::res_t r);
    int unsigned w;
    w = byte_idx_q >> 2;
    if (byte_idx_q >= count_q || w >= DATA_WORDS) begin
      complete_xfer(1'b0, r);
    end else if (ctrl_q[1:0] == i2cmrc_pkg::DIR_RX) begin
      r.bus_cmd = i2cmrc_pkg::CMD_RECV;
      phase_q = i2cmrc_pkg::PH_RECV;
    end else begin
      r.bus_cmd = i2cmrc_pkg::CMD_SEND;
      r.bus_byte = tx_q[w][8 * byte_idx_q[1:0] +: 8];
      phase_q = i2cmrc_pkg::PH_SEND;
    end
  endfunction

  function automatic void start_xfer(inout i2cmrc_pkg::res_t r);
    if (!released_q || count_q > 4 * DATA_WORDS || ctrl_q[1:0] > i2cmrc_pkg::DIR_RX) begin
      complete_xfer(1'b1, r);
      return;
    end
    byte_idx_q = '0;
    if (en_q[i2cmrc_pkg::EN_NOSTART_BIT]) begin
      if (!bus_open_q) complete_xfer(1'b1, r);
      else issue_next_byte(r);
      return;
    end
    r.bus_cmd = i2cmrc_pkg::CMD_START;
    r.bus_addr = addr_q[7:1];
    r.bus_read = ctrl_q[0];
    bus_open_q = 1'b1;
    phase_q = i2cmrc_pkg::PH_START;
  endfunction

  function automatic bit read_main(input logic [9:0] off, output logic [31:0] v);
    int unsigned wi;
    wi = off[9:2];
    v = '0;
    if (off[1:0] != 2'b00) return 1'b0;
    if (wi >= i2cmrc_pkg::TX_WORD_BASE && wi < i2cmrc_pkg::TX_WORD_BASE + DATA_WORDS) begin
      v = tx_q[wi - i2cmrc_pkg::TX_WORD_BASE];
      return 1'b1;
    end
    if (wi >= i2cmrc_pkg::RX_WORD_BASE && wi < i2cmrc_pkg::RX_WORD_BASE + DATA_WORDS) begin
      v = rx_q[wi - i2cmrc_pkg::RX_WORD_BASE];
      return 1'b1;
    end
    case (off)
      i2cmrc_pkg::OFF_ADDR:    v = {24'b0, addr_q};
      i2cmrc_pkg::OFF_COUNT:   v = {26'b0, count_q};
      i2cmrc_pkg::OFF_CTRL:    v = {24'b0, ctrl_q};
      i2cmrc_pkg::OFF_EN:      v = {25'b0, en_q};
      i2cmrc_pkg::OFF_CTRL_HI: v = {24'b0, ctrl_hi_q};
      i2cmrc_pkg::OFF_CLK:     v = clkdiv_q;
      default:                 return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic bit write_main(input logic [9:0] off, input logic [31:0] val,
                                    inout i2cmrc_pkg::res_t r);
    int unsigned wi;
    wi = off[9:2];
    if (off[1:0] != 2'b00) return 1'b0;
    if (wi >= i2cmrc_pkg::TX_WORD_BASE && wi < i2cmrc_pkg::TX_WORD_BASE + DATA_WORDS) begin
      tx_q[wi - i2cmrc_pkg::TX_WORD_BASE] = val;
      return 1'b1;
    end
    if (wi >= i2cmrc_pkg::RX_WORD_BASE && wi < i2cmrc_pkg::RX_WORD_BASE + DATA_WORDS) begin
      return 1'b1;
    end
    case (off)
      i2cmrc_pkg::OFF_ADDR:    addr_q = val[7:0];
      i2cmrc_pkg::OFF_COUNT:   count_q = val[5:0];
      i2cmrc_pkg::OFF_CTRL:    ctrl_q = val[7:0] & i2cmrc_pkg::CTRL_MASK;
      i2cmrc_pkg::OFF_EN: begin
        en_q = val[6:0] & i2cmrc_pkg::EN_WR_MASK;
        if (en_q[i2cmrc_pkg::EN_XFER_BIT]) start_xfer(r);
      end
      i2cmrc_pkg::OFF_CTRL_HI: ctrl_hi_q = val[7:0] & i2cmrc_pkg::CTRL_HI_MASK;
      i2cmrc_pkg::OFF_CLK:     clkdiv_q = val;
      default:                 return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic i2cmrc_pkg::res_t advance_controller(i2cmrc_pkg::item_t it);
    i2cmrc_pkg::res_t r;
    int unsigned      w;
    r = '0;
    if ((it.req_type == i2cmrc_pkg::REQ_MAIN_WR || it.req_type == i2cmrc_pkg::REQ_AUX_WR) &&
        phase_q != i2cmrc_pkg::PH_IDLE) begin
      r.busy_reject = 1'b1;
      return r;
    end
    case (it.req_type)
      i2cmrc_pkg::REQ_MAIN_RD: begin
        if (!read_main(it.offset, r.read_data)) r.access_error = 1'b1;
      end
      i2cmrc_pkg::REQ_MAIN_WR: begin
        if (!write_main(it.offset, it.wdata, r)) r.access_error = 1'b1;
      end
      i2cmrc_pkg::REQ_AUX_RD: begin
        if (it.offset != i2cmrc_pkg::OFF_AUX_CTRL) r.access_error = 1'b1;
      end
      i2cmrc_pkg::REQ_AUX_WR: begin
        if (it.offset != i2cmrc_pkg::OFF_AUX_CTRL) r.access_error = 1'b1;
        else if (it.wdata[i2cmrc_pkg::AUX_RELEASE_BIT]) released_q = 1'b1;
      end
      i2cmrc_pkg::REQ_RESP: begin
        case (phase_q)
          i2cmrc_pkg::PH_START: begin
            if (!it.target_ack) begin
              bus_open_q = 1'b0;
              complete_xfer(1'b1, r);
            end else begin
              issue_next_byte(r);
            end
          end
          i2cmrc_pkg::PH_SEND: begin
            if (!it.target_ack) begin
              complete_xfer(1'b1, r);
            end else begin
              byte_idx_q = byte_idx_q + 6'd1;
              issue_next_byte(r);
            end
          end
          i2cmrc_pkg::PH_RECV: begin
            w = byte_idx_q >> 2;
            if (w < DATA_WORDS) rx_q[w][8 * byte_idx_q[1:0] +: 8] = it.rx_byte;
            byte_idx_q = byte_idx_q + 6'd1;
            issue_next_byte(r);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(i2cmrc_pkg::item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= it.req_type;
    offset_i     <= it.offset;
    wdata_i      <= it.wdata;
    target_ack_i <= it.target_ack;
    rx_byte_i    <= it.rx_byte;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_responses.push_back(advance_controller(it));
  endtask

  task automatic send_req(logic [2:0] req, logic [9:0] off, logic [31:0] data = '0,
                          logic ack = 1'b0, logic [7:0] rxb = '0);
    i2cmrc_pkg::item_t it;
    it.req_type   = req;
    it.offset     = off;
    it.wdata      = data;
    it.target_ack = ack;
    it.rx_byte    = rxb;
    send_item(it);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_responses.size() != 0);
  endtask

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_responses.size() == 0) begin
        $error("result transfer with no request outstanding");
        errors++;
      end else begin
        due = pending_responses.pop_front();
        check_field("read_data", due.read_data, read_data_o);
        check_field("access_error", due.access_error, access_error_o);
        check_field("busy_reject", due.busy_reject, busy_reject_o);
        check_field("bus_cmd", due.bus_cmd, bus_cmd_o);
        check_field("bus_addr", due.bus_addr, bus_addr_o);
        check_field("bus_read", due.bus_read, bus_read_o);
        check_field("bus_byte", due.bus_byte, bus_byte_o);
        check_field("transfer_done", due.transfer_done, transfer_done_o);
      end
    end
  end

  task automatic test_register_map();
    send_req(i2cmrc_pkg::REQ_MAIN_RD, i2cmrc_pkg::OFF_EN);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_ADDR, 32'hffff_ffff);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_CTRL_HI, 32'hffff_ffff);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_CLK, 32'hffff_ffff);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, tx_off(0), 32'hffff_ffff);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, tx_off(DATA_WORDS - 1), 32'ha5a5_5a5a);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, rx_off(DATA_WORDS - 1), 32'hffff_ffff);
    send_req(i2cmrc_pkg::REQ_MAIN_RD, rx_off(DATA_WORDS - 1));
    send_req(i2cmrc_pkg::REQ_MAIN_RD, i2cmrc_pkg::OFF_CLK);
    send_req(i2cmrc_pkg::REQ_MAIN_RD, 10'h3fc);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, 10'h3fe, 32'hffff_ffff);
    send_req(i2cmrc_pkg::REQ_MAIN_RD, 10'h002);
    send_req(i2cmrc_pkg::REQ_AUX_RD, i2cmrc_pkg::OFF_AUX_CTRL);
    send_req(i2cmrc_pkg::REQ_AUX_WR, 10'h3ff, 32'hffff_ffff);
    send_req(3'd7, 10'h3ff, 32'hffff_ffff, 1'b1, 8'hff);
    send_req(i2cmrc_pkg::REQ_RESP, i2cmrc_pkg::OFF_ADDR, 32'h0, 1'b1, 8'hff);
    settle();
  endtask

  task automatic test_refusals();
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_CTRL_HI, 32'h0);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_COUNT, 32'd4);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_EN, 32'h01);
    send_req(i2cmrc_pkg::REQ_AUX_WR, i2cmrc_pkg::OFF_AUX_CTRL, 32'h2);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_EN, 32'hffff_ff21);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_COUNT, 32'd33);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_EN, 32'h01);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_COUNT, 32'd2);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_CTRL, 32'h3);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_EN, 32'h01);
    settle();
  endtask

  task automatic test_transfers();
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_CTRL, 32'h0);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, tx_off(0), 32'h0000_beef);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_EN, 32'h01);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_ADDR, 32'h12);
    send_req(i2cmrc_pkg::REQ_AUX_WR, i2cmrc_pkg::OFF_AUX_CTRL, 32'h2);
    send_req(i2cmrc_pkg::REQ_MAIN_RD, i2cmrc_pkg::OFF_EN);
    send_req(i2cmrc_pkg::REQ_RESP, i2cmrc_pkg::OFF_ADDR, 32'h0, 1'b1);
    send_req(i2cmrc_pkg::REQ_RESP, i2cmrc_pkg::OFF_ADDR, 32'h0, 1'b1);
    send_req(i2cmrc_pkg::REQ_RESP, i2cmrc_pkg::OFF_ADDR, 32'h0, 1'b0);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_CTRL, 32'h1);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_EN, 32'h11);
    send_req(i2cmrc_pkg::REQ_RESP, i2cmrc_pkg::OFF_ADDR, 32'h0, 1'b1);
    send_req(i2cmrc_pkg::REQ_RESP, i2cmrc_pkg::OFF_ADDR, 32'h0, 1'b0, 8'h12);
    send_req(i2cmrc_pkg::REQ_RESP, i2cmrc_pkg::OFF_ADDR, 32'h0, 1'b1, 8'h34);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_EN, 32'h21);
    send_req(i2cmrc_pkg::REQ_RESP, i2cmrc_pkg::OFF_ADDR, 32'h0, 1'b0, 8'h56);
    send_req(i2cmrc_pkg::REQ_RESP, i2cmrc_pkg::OFF_ADDR, 32'h0, 1'b0, 8'h78);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_COUNT, 32'd0);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_EN, 32'h01);
    send_req(i2cmrc_pkg::REQ_RESP, i2cmrc_pkg::OFF_ADDR, 32'h0, 1'b0);
    send_req(i2cmrc_pkg::REQ_MAIN_WR, i2cmrc_pkg::OFF_EN, 32'h01);
    send_req(i2cmrc_pkg::REQ_RESP, i2cmrc_pkg::OFF_ADDR, 32'h0, 1'b1);
    settle();
  endtask

  function automatic logic [9:0] random_reg_offset();
    int unsigned k;
    k = $urandom_range(2 * DATA_WORDS + 5);
    if (k < DATA_WORDS) return tx_off(k);
    if (k < 2 * DATA_WORDS) return rx_off(k - DATA_WORDS);
    case (k - 2 * DATA_WORDS)
      0:       return i2cmrc_pkg::OFF_ADDR;
      1:       return i2cmrc_pkg::OFF_COUNT;
      2:       return i2cmrc_pkg::OFF_CTRL;
      3:       return i2cmrc_pkg::OFF_EN;
      4:       return i2cmrc_pkg::OFF_CTRL_HI;
      default: return i2cmrc_pkg::OFF_CLK;
    endcase
  endfunction

  function automatic i2cmrc_pkg::item_t random_item();
    i2cmrc_pkg::item_t it;
    int unsigned       pick;
    int unsigned       sel;
    logic [31:0]       w;
    w = $urandom();
    it.req_type   = i2cmrc_pkg::REQ_MAIN_RD;
    it.offset     = random_reg_offset();
    it.wdata      = $urandom();
    it.target_ack = 1'($urandom_range(1));
    it.rx_byte    = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (phase_q != i2cmrc_pkg::PH_IDLE) begin
      if (pick < 80) begin
        it.req_type = i2cmrc_pkg::REQ_RESP;
        it.target_ack = ($urandom_range(9) != 0);
      end else if (pick < 96) begin
        it.req_type = ($urandom_range(1) != 0) ? i2cmrc_pkg::REQ_MAIN_WR
                                               : i2cmrc_pkg::REQ_AUX_WR;
        if (pick < 90) it.req_type = i2cmrc_pkg::REQ_MAIN_RD;
        else if (it.req_type == i2cmrc_pkg::REQ_AUX_WR) it.offset = i2cmrc_pkg::OFF_AUX_CTRL;
      end else begin
        it.req_type = 3'($urandom_range(7));
        it.offset = 10'($urandom_range(1023));
      end
    end else if (pick < 20) begin
      w[i2cmrc_pkg::EN_XFER_BIT] = ($urandom_range(5) != 0);
      w[i2cmrc_pkg::EN_NOSTART_BIT] = ($urandom_range(5) == 0);
      w[i2cmrc_pkg::EN_NOSTOP_BIT] = ($urandom_range(3) == 0);
      it.req_type = i2cmrc_pkg::REQ_MAIN_WR;
      it.offset = i2cmrc_pkg::OFF_EN;
      it.wdata = w;
    end else if (pick < 30) begin
      sel = $urandom_range(19);
      if (sel == 0) w[5:0] = 6'(4 * DATA_WORDS);
      else if (sel == 1) w[5:0] = 6'($urandom_range(63, 4 * DATA_WORDS + 1));
      else if (sel == 2) w[5:0] = 6'($urandom_range(4 * DATA_WORDS - 1));
      else w[5:0] = 6'($urandom_range(8));
      it.req_type = i2cmrc_pkg::REQ_MAIN_WR;
      it.offset = i2cmrc_pkg::OFF_COUNT;
      it.wdata = w;
    end else if (pick < 38) begin
      w[1:0] = ($urandom_range(9) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1));
      it.req_type = i2cmrc_pkg::REQ_MAIN_WR;
      it.offset = i2cmrc_pkg::OFF_CTRL;
      it.wdata = w;
    end else if (pick < 50) begin
      it.req_type = i2cmrc_pkg::REQ_MAIN_WR;
      it.offset = tx_off($urandom_range(DATA_WORDS - 1));
    end else if (pick < 55) begin
      it.req_type = i2cmrc_pkg::REQ_MAIN_WR;
      it.offset = i2cmrc_pkg::OFF_ADDR;
    end else if (pick < 60) begin
      it.req_type = i2cmrc_pkg::REQ_MAIN_WR;
      it.offset = ($urandom_range(1) != 0) ? i2cmrc_pkg::OFF_CTRL_HI : i2cmrc_pkg::OFF_CLK;
    end else if (pick < 65) begin
      it.req_type = ($urandom_range(3) != 0) ? i2cmrc_pkg::REQ_AUX_WR : i2cmrc_pkg::REQ_AUX_RD;
      it.offset = i2cmrc_pkg::OFF_AUX_CTRL;
    end else if (pick < 85) begin
      it.req_type = i2cmrc_pkg::REQ_MAIN_RD;
    end else begin
      it.req_type = 3'($urandom_range(7));
      it.offset = 10'($urandom_range(1023));
    end
    return it;
  endfunction

  task automatic test_random_traffic();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      repeat (RANDOM_PER_PHASE) send_item(random_item());
      settle();
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_map();
    test_refusals();
    test_transfers();
    test_random_traffic();
    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
sv/i2cmrc_pkg.sv
sv/i2cmrc_engine.sv
sv/i2c_master_register_controller_core.sv
sv/i2cmrc_checker.sv
test/i2c_master_register_controller_core_test.sv
